// File: sv/glu_pkg.sv
// Shared types and constants of the GCD / LCM unit: microcode word layout,
// datapath operations, jump conditions and status flags.
// Depends on nothing; every other file of the unit imports it.
package glu_pkg;

   // Field widths of the request and response words
   localparam int OPERAND_PORT_W        = 16;
   localparam int DIVISOR_W             = 16;
   localparam int MULTIPLE_W            = 32;
   localparam int OPERAND_WIDTH_DEFAULT = 16;

   // Microprogram counter
   localparam int UPC_W       = 4;
   localparam int UCODE_DEPTH = 10;

   // Microprogram entry points
   localparam logic [UPC_W-1:0] STEP_CHECK      = UPC_W'(0);
   localparam logic [UPC_W-1:0] STEP_STRIP_BOTH = UPC_W'(1);
   localparam logic [UPC_W-1:0] STEP_STRIP_X    = UPC_W'(2);
   localparam logic [UPC_W-1:0] STEP_REDUCE     = UPC_W'(3);
   localparam logic [UPC_W-1:0] STEP_RESTORE    = UPC_W'(4);
   localparam logic [UPC_W-1:0] STEP_DIV_INIT   = UPC_W'(5);
   localparam logic [UPC_W-1:0] STEP_DIV        = UPC_W'(6);
   localparam logic [UPC_W-1:0] STEP_MULTIPLY   = UPC_W'(7);
   localparam logic [UPC_W-1:0] STEP_ZERO       = UPC_W'(8);
   localparam logic [UPC_W-1:0] STEP_FINISH     = UPC_W'(9);

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_STRIP_BOTH,
      OP_STRIP_X,
      OP_REDUCE,
      OP_RESTORE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MULTIPLY,
      OP_SET_ZERO,
      OP_FINISH
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_ZERO_OPERAND,
      COND_BOTH_EVEN,
      COND_X_EVEN,
      COND_Y_NONZERO,
      COND_K_NONZERO,
      COND_COUNT_NONZERO
   } cond_type;

   // One control word of the microprogram
   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ucode_word_type;

   // Flags the datapath reports to the sequencer
   typedef struct packed {
      logic zero_operand;
      logic both_even;
      logic x_even;
      logic y_nonzero;
      logic k_nonzero;
      logic count_nonzero;
   } dp_status_type;

endpackage

// File: sv/glu_ucode_rom.sv
// Read-only microprogram of the GCD / LCM unit: binary GCD, restore of the
// common power of two, shift-subtract divide, one multiply.
// Depends on glu_pkg.
module glu_ucode_rom
   import glu_pkg::*;
(
   input  logic [UPC_W-1:0] upc,
   output ucode_word_type   word
);

   // Look up the control word of the current step
   always_comb begin
      case (upc)
         STEP_CHECK:      word = '{OP_NOP,        COND_ZERO_OPERAND,  STEP_ZERO};
         STEP_STRIP_BOTH: word = '{OP_STRIP_BOTH, COND_BOTH_EVEN,     STEP_STRIP_BOTH};
         STEP_STRIP_X:    word = '{OP_STRIP_X,    COND_X_EVEN,        STEP_STRIP_X};
         STEP_REDUCE:     word = '{OP_REDUCE,     COND_Y_NONZERO,     STEP_REDUCE};
         STEP_RESTORE:    word = '{OP_RESTORE,    COND_K_NONZERO,     STEP_RESTORE};
         STEP_DIV_INIT:   word = '{OP_DIV_INIT,   COND_NEXT,          STEP_CHECK};
         STEP_DIV:        word = '{OP_DIV_STEP,   COND_COUNT_NONZERO, STEP_DIV};
         STEP_MULTIPLY:   word = '{OP_MULTIPLY,   COND_ALWAYS,        STEP_FINISH};
         STEP_ZERO:       word = '{OP_SET_ZERO,   COND_NEXT,          STEP_CHECK};
         STEP_FINISH:     word = '{OP_FINISH,     COND_NEXT,          STEP_CHECK};
         // unused addresses end the program
         default:         word = '{OP_FINISH,     COND_NEXT,          STEP_CHECK};
      endcase
   end

endmodule

// File: sv/glu_sequencer.sv
// Microprogram sequencer of the GCD / LCM unit: busy flag, step counter,
// conditional jumps and the response strobe.
// Depends on glu_pkg and glu_ucode_rom.
module glu_sequencer
   import glu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output logic          busy,
   output op_type        dp_op,
   output logic          strobe
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             strobe_ff, strobe_in;
   ucode_word_type   word;
   logic             take;
   logic             jump;

   glu_ucode_rom u_rom (
      .upc  (upc_ff),
      .word (word)
   );

   assign take = start && !busy_ff;

   // Evaluate the jump condition of the current step
   always_comb begin
      case (word.cond)
         COND_NEXT:          jump = 1'b0;
         COND_ALWAYS:        jump = 1'b1;
         COND_ZERO_OPERAND:  jump = status.zero_operand;
         COND_BOTH_EVEN:     jump = status.both_even;
         COND_X_EVEN:        jump = status.x_even;
         COND_Y_NONZERO:     jump = status.y_nonzero;
         COND_K_NONZERO:     jump = status.k_nonzero;
         COND_COUNT_NONZERO: jump = status.count_nonzero;
         default:            jump = 1'b0;
      endcase
   end

   // Drive the datapath: load on accept, microcode while busy
   always_comb begin
      if (take) begin
         dp_op = OP_LOAD;
      end else if (busy_ff) begin
         dp_op = word.op;
      end else begin
         dp_op = OP_NOP;
      end
   end

   // Advance the step counter, end the program on the finish step
   always_comb begin
      busy_in   = busy_ff;
      upc_in    = upc_ff;
      strobe_in = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            upc_in  = STEP_CHECK;
         end
      end else if (word.op == OP_FINISH) begin
         busy_in   = 1'b0;
         strobe_in = 1'b1;
      end else if (jump) begin
         upc_in = word.target;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         upc_ff    <= STEP_CHECK;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         upc_ff    <= upc_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy   = busy_ff;
   assign strobe = strobe_ff;

   // A strobe only follows a busy cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(busy_ff))
      else $error("response strobe without a running operation");

   // An accepted word starts the program at its first step
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      take |=> (busy_ff && upc_ff == STEP_CHECK))
      else $error("accepted word did not start the microprogram");

   // The finish step ends the operation with exactly one strobe
   a_finish_strobes: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && word.op == OP_FINISH) |=> (strobe_ff && !busy_ff))
      else $error("finish step did not deliver the response");

endmodule

// File: sv/glu_datapath.sv
// Datapath of the GCD / LCM unit: operand registers, binary GCD shift and
// subtract, one-bit-per-cycle divider and the final multiplier.
// Depends on glu_pkg.
module glu_datapath
   import glu_pkg::*;
#(
   parameter int OPW = OPERAND_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  op_type                    dp_op,
   input  logic [OPERAND_PORT_W-1:0] operand_a,
   input  logic [OPERAND_PORT_W-1:0] operand_b,
   output dp_status_type             status,
   output logic [DIVISOR_W-1:0]      common_divisor,
   output logic [MULTIPLE_W-1:0]     common_multiple
);

   localparam int CNT_W = $clog2(OPW + 1);

   logic [OPW-1:0]   a_ff, a_in;
   logic [OPW-1:0]   b_ff, b_in;
   logic [OPW-1:0]   x_ff, x_in;
   logic [OPW-1:0]   y_ff, y_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OPW-1:0]   rem_ff, rem_in;
   logic [OPW-1:0]   quo_ff, quo_in;
   logic [2*OPW-1:0] prod_ff, prod_in;
   logic [OPW:0]     shifted;
   logic [OPW:0]     trial;

   // Divide step: bring in the next dividend bit and try the subtract
   assign shifted = {rem_ff, quo_ff[OPW-1]};
   assign trial   = shifted - {1'b0, x_ff};

   // Execute the operation of the current step
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      prod_in = prod_ff;
      case (dp_op)
         OP_LOAD: begin
            a_in = OPW'(operand_a);
            b_in = OPW'(operand_b);
            x_in = OPW'(operand_a);
            y_in = OPW'(operand_b);
            k_in = '0;
         end
         OP_STRIP_BOTH: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CNT_W'(1);
            end
         end
         OP_STRIP_X: begin
            if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end
         end
         OP_REDUCE: begin
            // x is odd; drop twos from y, else subtract the smaller odd value
            if (y_ff != '0) begin
               if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end else if (x_ff > y_ff) begin
                  x_in = y_ff;
                  y_in = x_ff - y_ff;
               end else begin
                  y_in = y_ff - x_ff;
               end
            end
         end
         OP_RESTORE: begin
            if (k_ff != '0) begin
               x_in = x_ff << 1;
               k_in = k_ff - CNT_W'(1);
            end
         end
         OP_DIV_INIT: begin
            rem_in = '0;
            quo_in = a_ff;
            cnt_in = CNT_W'(OPW);
         end
         OP_DIV_STEP: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (!trial[OPW]) begin
                  rem_in = trial[OPW-1:0];
                  quo_in = {quo_ff[OPW-2:0], 1'b1};
               end else begin
                  rem_in = shifted[OPW-1:0];
                  quo_in = {quo_ff[OPW-2:0], 1'b0};
               end
            end
         end
         OP_MULTIPLY: begin
            prod_in = (2*OPW)'(quo_ff) * (2*OPW)'(b_ff);
         end
         OP_SET_ZERO: begin
            x_in    = OPW'(1);
            prod_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
   end

   // Report flags for the jump conditions
   assign status.zero_operand  = (x_ff == '0) || (y_ff == '0);
   assign status.both_even     = !x_ff[0] && !y_ff[0];
   assign status.x_even        = !x_ff[0];
   assign status.y_nonzero     = (y_ff != '0);
   assign status.k_nonzero     = (k_ff != '0);
   assign status.count_nonzero = (cnt_ff != '0);

   assign common_divisor  = DIVISOR_W'(x_ff);
   assign common_multiple = MULTIPLE_W'(prod_ff);

   // The divisor never reaches zero while dividing
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (dp_op == OP_DIV_STEP) |-> (x_ff != '0))
      else $error("divide step with a zero divisor");

   // The divisor found must divide the first operand exactly
   a_exact_quotient: assert property (@(posedge clock) disable iff (reset)
      (dp_op == OP_MULTIPLY) |-> (rem_ff == '0))
      else $error("divisor leaves a remainder on the first operand");

endmodule

// File: sv/gcd_lcm_unit.sv
// Top level of the GCD / LCM unit: ties the microcoded sequencer to the
// datapath. Depends on glu_pkg, glu_sequencer and glu_datapath.
//
// A request word (req_operand_a, req_operand_b) is taken at a rising edge with
// start high and busy low; only the low OPERAND_WIDTH bits of each operand
// count. Exactly one response follows: rsp_common_divisor and
// rsp_common_multiple are valid for the single cycle in which rsp_strobe is
// high, and the receiver must take them then, since the unit cannot be held
// off. busy falls in that same cycle, so the next request may be taken at the
// edge that ends it. If either operand is zero the answer is divisor 1,
// multiple 0. Otherwise the time is data dependent: the binary GCD loops of
// the microprogram (shift and subtract, one step a cycle) run first, then the
// restore of the common power of two, the shift-subtract divide of the first
// operand by the divisor, one multiply and a finish step.
module gcd_lcm_unit
   import glu_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OPERAND_PORT_W-1:0] req_operand_a,
   input  logic [OPERAND_PORT_W-1:0] req_operand_b,
   output logic                      rsp_strobe,
   output logic [DIVISOR_W-1:0]      rsp_common_divisor,
   output logic [MULTIPLE_W-1:0]     rsp_common_multiple
);

   op_type        dp_op;
   dp_status_type status;

   // Step through the microprogram
   glu_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .dp_op  (dp_op),
      .strobe (rsp_strobe)
   );

   // Execute the control words
   glu_datapath #(
      .OPW (OPERAND_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_op           (dp_op),
      .operand_a       (req_operand_a),
      .operand_b       (req_operand_b),
      .status          (status),
      .common_divisor  (rsp_common_divisor),
      .common_multiple (rsp_common_multiple)
   );

endmodule
